FILE: src/bbpg_pkg.sv
// Shared types and constants for the beeper burst pattern generator.
package bbpg_pkg;

  // Widths of the item fields
  localparam int unsigned WIDTH_BITS = 8;
  localparam int unsigned COUNT_BITS = 8;
  localparam int unsigned REQ_BITS   = 2;

  // Request codes carried by req_type; the fourth code means nothing
  typedef enum logic [REQ_BITS-1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_code_t;

  // Command waiting for the next tick
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_START = 2'd1,
    PEND_STOP  = 2'd2
  } pend_t;

  // One input item
  typedef struct packed {
    logic [REQ_BITS-1:0]   req_type;
    logic [WIDTH_BITS-1:0] beep_width;
    logic [COUNT_BITS-1:0] beep_count;
  } req_t;

  // One result item
  typedef struct packed {
    logic amp_enable;
    logic tone_on;
    logic busy_res;
  } res_t;

endpackage

FILE: src/bbpg_if.sv
// Handshake interfaces for the request and result channels.
interface bbpg_req_if;
  logic                                valid;
  logic                                ready;
  logic [bbpg_pkg::REQ_BITS-1:0]       req_type;
  logic [bbpg_pkg::WIDTH_BITS-1:0]     beep_width;
  logic [bbpg_pkg::COUNT_BITS-1:0]     beep_count;

  modport source (output valid, output req_type, output beep_width, output beep_count,
                  input ready);
  modport sink   (input valid, input req_type, input beep_width, input beep_count,
                  output ready);
endinterface

interface bbpg_res_if;
  logic valid;
  logic ready;
  logic amp_enable;
  logic tone_on;
  logic busy_res;

  modport source (output valid, output amp_enable, output tone_on, output busy_res,
                  input ready);
  modport sink   (input valid, input amp_enable, input tone_on, input busy_res,
                  output ready);
endinterface

FILE: src/bbpg_seq.sv
// Tone sequencer state and its single-step update for one item.
module bbpg_seq #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  bbpg_pkg::req_t  item,
  output bbpg_pkg::res_t  result
);

  localparam logic [COUNTER_BITS-1:0] CNT_ONE  = {{(COUNTER_BITS-1){1'b0}}, 1'b1};
  localparam logic [COUNTER_BITS-1:0] CNT_ZERO = '0;

  bbpg_pkg::pend_t         pending_cmd, pending_cmd_next;
  logic                    active, active_next;
  logic [COUNTER_BITS-1:0] period_ticks, period_ticks_next;
  logic [COUNTER_BITS-1:0] bursts_left, bursts_left_next;
  logic [COUNTER_BITS-1:0] tick_down, tick_down_next;
  logic                    phase, phase_next;
  logic                    amp_on, amp_on_next;
  logic                    sounding, sounding_next;

  // Widen the fields to 16 bits, then cut to the counter width (wraps when narrower)
  logic [15:0] count_ext;
  logic [15:0] width_dbl;
  assign count_ext = {8'd0, item.beep_count};
  assign width_dbl = {7'd0, item.beep_width, 1'b0};

  // Next state for the item in the input register
  always_comb begin
    pending_cmd_next  = pending_cmd;
    active_next       = active;
    period_ticks_next = period_ticks;
    bursts_left_next  = bursts_left;
    tick_down_next    = tick_down;
    phase_next        = phase;
    amp_on_next       = amp_on;
    sounding_next     = sounding;

    case (item.req_type)
      bbpg_pkg::REQ_START: begin
        bursts_left_next  = count_ext[COUNTER_BITS-1:0];
        period_ticks_next = width_dbl[COUNTER_BITS-1:0];
        pending_cmd_next  = bbpg_pkg::PEND_START;
      end
      bbpg_pkg::REQ_STOP: begin
        pending_cmd_next = bbpg_pkg::PEND_STOP;
      end
      bbpg_pkg::REQ_TICK: begin
        // Apply the waiting command first
        if (pending_cmd == bbpg_pkg::PEND_START) begin
          amp_on_next    = 1'b1;
          phase_next     = 1'b0;
          active_next    = 1'b1;
          tick_down_next = CNT_ONE;
        end else if (pending_cmd == bbpg_pkg::PEND_STOP) begin
          amp_on_next    = 1'b0;
          active_next    = 1'b0;
          tick_down_next = CNT_ONE;
        end
        pending_cmd_next = bbpg_pkg::PEND_NONE;

        // Advance the tone
        if (!active_next) begin
          // Silence the tone once after a sequence ends
          if (tick_down_next != CNT_ZERO) begin
            sounding_next  = 1'b0;
            tick_down_next = CNT_ZERO;
          end
        end else if (period_ticks != CNT_ZERO) begin
          // Burst mode: toggle every period, count a burst when the tone drops
          if (|tick_down_next[COUNTER_BITS-1:1]) begin
            tick_down_next = tick_down_next - CNT_ONE;
          end else if (bursts_left != CNT_ZERO) begin
            tick_down_next = period_ticks;
            phase_next     = ~phase_next;
            sounding_next  = phase_next;
            if (!phase_next) begin
              bursts_left_next = bursts_left - CNT_ONE;
            end
          end else begin
            sounding_next  = 1'b0;
            active_next    = 1'b0;
            tick_down_next = CNT_ZERO;
          end
        end else if (bursts_left != CNT_ZERO) begin
          // Single tone lasting the count
          if (!phase_next) begin
            tick_down_next = bursts_left;
            phase_next     = 1'b1;
            sounding_next  = 1'b1;
          end else if (|tick_down_next[COUNTER_BITS-1:1]) begin
            tick_down_next = tick_down_next - CNT_ONE;
          end else begin
            sounding_next  = 1'b0;
            active_next    = 1'b0;
            tick_down_next = CNT_ZERO;
          end
        end else if (!phase_next) begin
          // Continuous tone
          phase_next    = 1'b1;
          sounding_next = 1'b1;
        end
      end
      default: begin
        // Unused request code: hold everything
      end
    endcase
  end

  // Hold the state; it also serves as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cmd  <= bbpg_pkg::PEND_NONE;
      active       <= 1'b0;
      period_ticks <= '0;
      bursts_left  <= '0;
      tick_down    <= '0;
      phase        <= 1'b0;
      amp_on       <= 1'b0;
      sounding     <= 1'b0;
    end else if (step) begin
      pending_cmd  <= pending_cmd_next;
      active       <= active_next;
      period_ticks <= period_ticks_next;
      bursts_left  <= bursts_left_next;
      tick_down    <= tick_down_next;
      phase        <= phase_next;
      amp_on       <= amp_on_next;
      sounding     <= sounding_next;
    end
  end

  assign result.amp_enable = amp_on;
  assign result.tone_on    = sounding;
  assign result.busy_res   = active;

endmodule

FILE: src/beeper_burst_pattern_generator.sv
// Top level of the beeper burst pattern generator.
// Each request item (a tick, a start command or a stop command) yields exactly one result
// item with the amplifier enable, tone and busy flags after that item. The block takes one
// item per clock cycle while its results are taken: an item is held in an input register,
// updated through the sequencer logic, and its result sits in the sequencer state itself,
// which serves as the result register, so a result is presented once its item has passed
// the input register and then the sequencer state. A result that waits to be taken
// stalls the sequencer, while the input register still takes one more item. COUNTER_BITS
// sets the width of the period and burst counters; the doubled width and the count wrap
// to it.
module beeper_burst_pattern_generator #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  bbpg_req_if.sink   req,
  bbpg_res_if.source res
);

  logic           in_valid;
  bbpg_pkg::req_t in_item;
  logic           out_valid;
  logic           step;
  bbpg_pkg::res_t seq_res;

  // Update the sequencer when an item waits and the result slot is free or being taken
  assign step      = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type   <= req.req_type;
      in_item.beep_width <= req.beep_width;
      in_item.beep_count <= req.beep_count;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  bbpg_seq #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .result (seq_res)
  );

  assign res.valid      = out_valid;
  assign res.amp_enable = seq_res.amp_enable;
  assign res.tone_on    = seq_res.tone_on;
  assign res.busy_res   = seq_res.busy_res;

endmodule
